FILE: src/sidec_pkg.sv
// Shared constants and control/status types for the signed decimal text converter.
package sidec_pkg;

	// Width of the integer that is converted; bits above it are ignored.
	localparam int VALUE_BITS = 64;

	// Number of decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
	function automatic int digit_count();
		logic [63:0] v;
		int n;
		v = 64'd1 << (VALUE_BITS - 1);
		n = 0;
		while (v != 64'd0) begin
			v = v / 64'd10;
			n = n + 1;
		end
		return n;
	endfunction

	localparam int DIGITS   = digit_count();
	localparam int BCD_W    = 4 * DIGITS;
	localparam int CNT_W    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int DLEFT_W  = $clog2(DIGITS + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic conv_step;
		logic skip_step;
		logic emit_sign;
		logic emit_digit;
	} sidec_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic conv_last;
		logic top_zero;
		logic one_left;
		logic neg;
	} sidec_sts_t;

endpackage

FILE: src/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, one character per transfer.
//
//  channel | signals                          | payload
//  in      | in_valid / in_ready              | value[63:0], low VALUE_BITS used
//  out     | out_valid / out_ready            | text_char[7:0], is_last
//
// One item at a time: accept, then bit-serial double-dabble in the datapath
// shifter over all VALUE_BITS input bits, then for each of the DIGITS digits
// either drop a leading zero or emit the digit through the output register,
// with a minus sign emitted ahead of the digits when the value is negative.
// arst_n clears the controller and output valid; no clearing pass is needed.
// A stalled output holds the character and pauses emission; in_ready rises
// once the last character is in the output register.
module signed_int_to_decimal_ascii
	import sidec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  text_char,
	output logic        is_last
);

	sidec_cmd_t cmd;
	sidec_sts_t sts;

	sidec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sidec_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.text_char (text_char),
		.is_last   (is_last)
	);

endmodule

FILE: src/sidec_dp.sv
// Datapath: magnitude, bit-serial binary to BCD shifter, digit emission registers.
module sidec_dp
	import sidec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [63:0]      value,
	input  sidec_cmd_t       cmd,
	output sidec_sts_t       sts,
	output logic [7:0]       text_char,
	output logic             is_last
);

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic                  neg_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DLEFT_W-1:0]    dig_left_q;
	logic [3:0]            top_digit;
	logic [7:0]            text_char_q;
	logic                  is_last_q;

	assign raw       = value[VALUE_BITS-1:0];
	assign top_digit = bcd_q[BCD_W-1 -: 4];

	// Add-3 correction on every BCD digit that is five or more
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Magnitude and BCD shift register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= raw[VALUE_BITS-1];
			mag_q <= raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
			bcd_q <= '0;
		end else if (cmd.conv_step) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
		end else if (cmd.skip_step || cmd.emit_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'b0000};
		end
	end

	// Step counter and remaining digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			dig_left_q <= '0;
		end else if (cmd.load) begin
			cnt_q      <= '0;
			dig_left_q <= DLEFT_W'(DIGITS);
		end else begin
			if (cmd.conv_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.skip_step || cmd.emit_digit) begin
				dig_left_q <= dig_left_q - 1'b1;
			end
		end
	end

	// Output character register
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			text_char_q <= CHAR_MINUS;
			is_last_q   <= 1'b0;
		end else if (cmd.emit_digit) begin
			text_char_q <= CHAR_ZERO + {4'b0000, top_digit};
			is_last_q   <= (dig_left_q == DLEFT_W'(1));
		end
	end

	assign sts.conv_last = (cnt_q == CNT_W'(VALUE_BITS - 1));
	assign sts.top_zero  = (top_digit == 4'd0);
	assign sts.one_left  = (dig_left_q == DLEFT_W'(1));
	assign sts.neg       = neg_q;

	assign text_char = text_char_q;
	assign is_last   = is_last_q;

endmodule

FILE: src/sidec_ctrl.sv
// Controller: sequences load, conversion, leading-zero skip and character output.
module sidec_ctrl
	import sidec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  sidec_sts_t sts,
	output sidec_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	// Output register can take a new character
	assign slot_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_last) begin
					state_nxt = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (sts.top_zero && !sts.one_left) begin
					cmd.skip_step = 1'b1;
				end else if (sts.neg) begin
					state_nxt = ST_SIGN;
				end else begin
					state_nxt = ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					cmd.emit_sign = 1'b1;
					state_nxt     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.one_left) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit_sign || cmd.emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: src/sidec_chk.sv
// Port-level checker for the decimal text converter, bound to the top level.
module sidec_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [63:0] value,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  text_char,
	input logic        is_last
);

	// A stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(is_last))
		else $error("output changed while stalled");

	// One item in flight: no transfer right after an input transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while converting");

	// Only a minus sign or a digit is shown
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (text_char == 8'h2D) || (text_char >= 8'h30 && text_char <= 8'h39))
		else $error("character outside sign and digits");

	// The sign never ends the text
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_char == 8'h2D |-> !is_last)
		else $error("minus sign flagged as last");

endmodule

bind signed_int_to_decimal_ascii sidec_chk u_sidec_chk (.*);
